// ----- rtl/tzoc_pkg.sv -----
// ----------------------------------------------------------------------------
// tzoc_pkg: shared types and constants of the two-zone occupancy counter
// Zone codes, combined zone states, event codes, widths and the item and
// result records passed between pipeline stages.
// ----------------------------------------------------------------------------
package tzoc_pkg;

  // Width of the internal people count
  localparam int COUNT_BITS = 16;
  // Width of the reported occupancy and of max_occupancy
  localparam int OCC_W      = 16;
  // Width used to compare the count against max_occupancy
  localparam int CMP_W      = (COUNT_BITS > OCC_W) ? COUNT_BITS : OCC_W;

  // Path queue fill level, 1..4
  localparam int FILL_W = 3;
  localparam logic [FILL_W-1:0] FILL_MIN = FILL_W'(1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(4);

  // Path queue: entries 1..3 are the only ones ever written or read
  localparam int QIDX_W     = 2;
  localparam int QUEUE_LAST = 3;

  localparam logic [OCC_W-1:0]      MAX_OCC_RST = OCC_W'(50);
  localparam logic [COUNT_BITS-1:0] COUNT_TOP   = {COUNT_BITS{1'b1}};

  // Zone selector codes
  localparam logic ZONE_INNER = 1'b0;
  localparam logic ZONE_OUTER = 1'b1;

  // Combined zone states: bit 0 inner, bit 1 outer
  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_INNER = 2'd1,
    ST_OUTER = 2'd2,
    ST_BOTH  = 2'd3
  } zone_state_t;

  // Event codes reported per reading
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTRY = 2'd1,
    EV_EXIT  = 2'd2
  } event_kind_t;

  // One presence reading
  typedef struct packed {
    logic zone;
    logic occupied;
  } item_t;

  // One result
  typedef struct packed {
    logic              zone_changed;
    event_kind_t       event_kind;
    logic [OCC_W-1:0]  occupancy;
    logic              at_capacity;
  } result_t;

endpackage

// ----- rtl/tzoc_ifs.sv -----
// ----------------------------------------------------------------------------
// tzoc_ifs: valid/ready channels of the two-zone occupancy counter
// The reading channel carries zone and occupied; the result channel carries
// zone_changed, event_kind, occupancy and at_capacity.
// ----------------------------------------------------------------------------
interface tzoc_in_if;
  logic valid;
  logic ready;
  logic zone;
  logic occupied;

  modport source (output valid, zone, occupied, input ready);
  modport sink   (input valid, zone, occupied, output ready);
endinterface

interface tzoc_out_if;
  logic        valid;
  logic        ready;
  logic        zone_changed;
  logic [1:0]  event_kind;
  logic [15:0] occupancy;
  logic        at_capacity;

  modport source (output valid, zone_changed, event_kind, occupancy, at_capacity,
                  input ready);
  modport sink   (input valid, zone_changed, event_kind, occupancy, at_capacity,
                  output ready);
endinterface

// ----- rtl/two_zone_occupancy_counter.sv -----
// ----------------------------------------------------------------------------
// two_zone_occupancy_counter: two-zone people counter, one reading per cycle
// Path: an accepted reading passes the input register, then the result register.
// Throughput: one reading per cycle unless out_ch stalls (single-step update).
// Reset (rst_n low, synchronous): both zones empty, path fill 1, count 0,
// max_occupancy 50, both pipeline stages empty.
// ----------------------------------------------------------------------------
module two_zone_occupancy_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  tzoc_in_if.sink                     in_ch,
  tzoc_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [tzoc_pkg::OCC_W-1:0]  cfg_wdata
);
  import tzoc_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    room;
  logic    step;
  result_t result;
  result_t out_result;

  assign in_item.zone     = in_ch.zone;
  assign in_item.occupied = in_ch.occupied;

  // Move the held reading through the tracker when the result stage is free
  assign step = held_valid && room;

  tzoc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .step       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  tzoc_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (held_item),
    .result    (result)
  );

  tzoc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .result     (result),
    .room       (room),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result)
  );

  assign out_ch.zone_changed = out_result.zone_changed;
  assign out_ch.event_kind   = out_result.event_kind;
  assign out_ch.occupancy    = out_result.occupancy;
  assign out_ch.at_capacity  = out_result.at_capacity;

endmodule

// ----- rtl/tzoc_in_reg.sv -----
// ----------------------------------------------------------------------------
// tzoc_in_reg: input register stage
// Captures one reading per transaction and holds it until the tracker
// consumes it; refills in the same cycle the held item moves on.
// ----------------------------------------------------------------------------
module tzoc_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tzoc_pkg::item_t in_item,
  input  logic            step,
  output logic            held_valid,
  output tzoc_pkg::item_t held_item
);
  import tzoc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready = !valid_r || step;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

// ----- rtl/tzoc_tracker.sv -----
// ----------------------------------------------------------------------------
// tzoc_tracker: zone state, path queue and people count
// Applies one reading per step: detects a zone change, records the combined
// state in the path queue, classifies a finished path and updates the count.
// ----------------------------------------------------------------------------
module tzoc_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tzoc_pkg::OCC_W-1:0]  cfg_wdata,
  input  logic                        step,
  input  tzoc_pkg::item_t             item,
  output tzoc_pkg::result_t           result
);
  import tzoc_pkg::*;

  logic                   inner_r, inner_nxt;
  logic                   outer_r, outer_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [1:0]             queue_r   [1:QUEUE_LAST];
  logic [1:0]             queue_nxt [1:QUEUE_LAST];
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [OCC_W-1:0]       max_occ_r;

  logic                   prev;
  logic                   changed;
  logic [1:0]             combined;
  logic [FILL_W-1:0]      fill_inc;
  logic [QIDX_W-1:0]      wr_idx;
  event_kind_t            kind;
  logic [CMP_W-1:0]       count_ext;
  logic                   is_entry;
  logic                   is_exit;

  // Detect a change in the reporting zone
  always_comb begin
    prev      = (item.zone == ZONE_INNER) ? inner_r : outer_r;
    changed   = (item.occupied != prev);
    inner_nxt = (changed && item.zone == ZONE_INNER) ? item.occupied : inner_r;
    outer_nxt = (changed && item.zone == ZONE_OUTER) ? item.occupied : outer_r;
    combined  = {outer_nxt, inner_nxt};
    fill_inc  = (fill_r < FILL_MAX) ? fill_r + FILL_W'(1) : fill_r;
    wr_idx    = QIDX_W'(fill_inc - FILL_W'(1));
  end

  // Match the recorded path against the entry and exit sequences
  assign is_entry = (queue_r[1] == ST_INNER) && (queue_r[2] == ST_BOTH) &&
                    (queue_r[3] == ST_OUTER);
  assign is_exit  = (queue_r[1] == ST_OUTER) && (queue_r[2] == ST_BOTH) &&
                    (queue_r[3] == ST_INNER);

  // Advance path queue, fill level and count
  always_comb begin
    kind      = EV_NONE;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    for (int i = 1; i <= QUEUE_LAST; i++) begin
      queue_nxt[i] = queue_r[i];
    end
    if (changed) begin
      if (combined == ST_EMPTY) begin
        fill_nxt = FILL_MIN;
        if (fill_inc == FILL_MAX) begin
          if (is_entry) begin
            kind = EV_ENTRY;
            if (count_r != COUNT_TOP) begin
              count_nxt = count_r + COUNT_BITS'(1);
            end
          end else if (is_exit) begin
            kind = EV_EXIT;
            if (count_r != '0) begin
              count_nxt = count_r - COUNT_BITS'(1);
            end
          end
        end
      end else begin
        fill_nxt = fill_inc;
        for (int i = 1; i <= QUEUE_LAST; i++) begin
          if (wr_idx == QIDX_W'(i)) begin
            queue_nxt[i] = combined;
          end
        end
      end
    end
  end

  // Build the result from the updated count
  assign count_ext           = CMP_W'(count_nxt);
  assign result.zone_changed = changed;
  assign result.event_kind   = kind;
  assign result.occupancy    = count_ext[OCC_W-1:0];
  assign result.at_capacity  = (count_ext >= CMP_W'(max_occ_r));

  // Hold tracking state; update once per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= 1'b0;
      outer_r <= 1'b0;
      fill_r  <= FILL_MIN;
      count_r <= '0;
      for (int i = 1; i <= QUEUE_LAST; i++) begin
        queue_r[i] <= ST_EMPTY;
      end
    end else if (step) begin
      inner_r <= inner_nxt;
      outer_r <= outer_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
      for (int i = 1; i <= QUEUE_LAST; i++) begin
        queue_r[i] <= queue_nxt[i];
      end
    end
  end

  // Capacity threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_occ_r <= MAX_OCC_RST;
    end else if (cfg_we) begin
      max_occ_r <= cfg_wdata;
    end
  end

endmodule

// ----- rtl/tzoc_out_reg.sv -----
// ----------------------------------------------------------------------------
// tzoc_out_reg: result register stage
// Holds one result until the downstream side takes it; loads a new result
// in the same cycle the held one is taken.
// ----------------------------------------------------------------------------
module tzoc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  tzoc_pkg::result_t result,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output tzoc_pkg::result_t out_result
);
  import tzoc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  // Free when empty or when the held result is taken now
  assign room = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (step) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ----- rtl/tzoc_checker.sv -----
// ----------------------------------------------------------------------------
// tzoc_checker: port-level checks of the two-zone occupancy counter
// Watches the result channel for reset, stall behavior and event consistency.
// ----------------------------------------------------------------------------
module tzoc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        zone_changed,
  input logic [1:0]                  event_kind,
  input logic [tzoc_pkg::OCC_W-1:0]  occupancy,
  input logic                        at_capacity
);
  import tzoc_pkg::*;

  // Drop any result during reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(zone_changed) &&
      $stable(event_kind) && $stable(occupancy) && $stable(at_capacity))
    else $error("stalled result changed");

  // An entry or exit only comes from a zone change
  a_event_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_kind == EV_ENTRY || event_kind == EV_EXIT) |-> zone_changed)
    else $error("event without zone change");

  // After an entry the count is never zero
  a_entry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == EV_ENTRY |-> occupancy != '0)
    else $error("entry left count at zero");

  // After an exit the count is below its top
  a_exit_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == EV_EXIT |-> occupancy != {OCC_W{1'b1}})
    else $error("exit left count at top");

endmodule

bind two_zone_occupancy_counter tzoc_checker u_tzoc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .zone_changed (out_ch.zone_changed),
  .event_kind   (out_ch.event_kind),
  .occupancy    (out_ch.occupancy),
  .at_capacity  (out_ch.at_capacity)
);
